// ===== hw/rtl/mgac_pkg.sv =====
package mgac_pkg;

  localparam int BW       = 48;
  localparam int DOMAINS  = 8;
  localparam int OWNERS   = 16;
  localparam int TICKETS  = 16;
  localparam int DOM_W    = 3;
  localparam int OWN_W    = 4;
  localparam int SLOT_W   = 4;
  localparam int DIV_W    = 16;
  localparam int IN_W     = 168;
  localparam int OUT_W    = 232;

  localparam logic [BW-1:0]    BMAX     = '1;

  // command codes
  localparam logic [2:0] CMD_UPDATE  = 3'd0;
  localparam logic [2:0] CMD_RESERVE = 3'd1;
  localparam logic [2:0] CMD_COMMIT  = 3'd2;
  localparam logic [2:0] CMD_CANCEL  = 3'd3;
  localparam logic [2:0] CMD_ALLOC   = 3'd4;
  localparam logic [2:0] CMD_RELEASE = 3'd5;

  // config register indexes
  localparam logic [1:0] REG_MIN_GROWTH = 2'd0;
  localparam logic [1:0] REG_MAX_GROWTH = 2'd1;
  localparam logic [1:0] REG_DIVISOR    = 2'd2;

  // per-domain record kept in one memory word
  typedef struct packed {
    logic [BW-1:0] usage;
    logic [BW-1:0] budget;
    logic          estimated;
    logic [BW-1:0] allowance;
    logic [BW-1:0] reserved;
    logic [BW-1:0] committed;
    logic          pressure;
    logic [31:0]   generation;
  } dom_rec_t;

  // ticket slot entry
  typedef struct packed {
    logic [OWN_W-1:0] owner;
    logic [DOM_W-1:0] domain;
    logic [BW-1:0]    bytes;
  } slot_rec_t;

  // owner committed entry, tagged with the domain generation
  typedef struct packed {
    logic [31:0]   tag;
    logic [BW-1:0] bytes;
  } own_rec_t;

  function automatic logic [BW-1:0] sat_add(input logic [BW-1:0] a, input logic [BW-1:0] b);
    logic [BW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BW] ? BMAX : s[BW-1:0];
  endfunction

  function automatic logic [BW-1:0] clamp_sub(input logic [BW-1:0] a, input logic [BW-1:0] b);
    return (b < a) ? a - b : '0;
  endfunction

endpackage

// ===== hw/rtl/mgac_div.sv =====
module mgac_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mgac_pkg::BW-1:0]    dividend,
  input  logic [mgac_pkg::DIV_W-1:0] divisor,
  output logic                       done,
  output logic [mgac_pkg::BW-1:0]    quotient
);

  logic                       busy;
  logic [5:0]                 cnt;
  logic [mgac_pkg::DIV_W-1:0] dsr;
  logic [mgac_pkg::DIV_W:0]   rem;
  logic [mgac_pkg::DIV_W:0]   trial;
  logic                       ge;

  // one quotient bit per cycle
  assign trial = {rem[mgac_pkg::DIV_W-1:0], quotient[mgac_pkg::BW-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        dsr      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= ge ? trial - {1'b0, dsr} : trial;
        quotient <= {quotient[mgac_pkg::BW-2:0], ge};
        cnt      <= cnt + 6'd1;
        if (cnt == 6'(mgac_pkg::BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/memory_growth_admission_control_core.sv =====
// Memory growth admission control for eight memory domains.
// Requests arrive on the s_ stream, one decision snapshot per request
// leaves on the m_ stream. Budgets and totals live in a domain memory,
// per-owner committed bytes in a tagged owner memory, tickets in a slot
// memory; each request reads them once, is processed, and writes back.
// Configuration (minimum growth, maximum growth, headroom divisor) is
// written through cfg_we / cfg_index / cfg_data; the user must write it
// only while no request is open, the block itself does not enforce this.
// Every command passes the read and write-back steps into the output
// register; a budget update also runs one serial 48-bit division
// (headroom by the divisor) in between. The 90% and 80% levels are
// compared through small constant multiples, no division needed.
// One request is in work at a time: s_tready is high only in idle. A new
// request may be accepted while the previous result still waits in the
// output register; if the receiver stalls, the block holds its finished
// result in the write-back step until the output register frees.
// Reset (rst, synchronous) returns all domains, owners and slots to zero
// immediately through valid bits; no clearing pass is needed.
module memory_growth_admission_control_core (
  input  logic                        clk,
  input  logic                        rst,
  // command, domain, owner, bytes, ticket_slot, usage_bytes, budget_bytes,
  // usage_estimated, zero fill
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mgac_pkg::IN_W-1:0]   s_tdata,
  // accepted, granted_ticket, memory_pressure, growth_allowance,
  // reserved_total, committed_total, effective_usage, snapshot_count, zero fill
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mgac_pkg::OUT_W-1:0]  m_tdata,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [mgac_pkg::BW-1:0]     cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_WB} state_t;
  state_t state;

  localparam int BW = mgac_pkg::BW;

  // small constant multiples for the threshold compares
  function automatic logic [BW+3:0] mul5(input logic [BW-1:0] v);
    return ({4'b0, v} << 2) + {4'b0, v};
  endfunction

  function automatic logic [BW+3:0] mul9(input logic [BW-1:0] v);
    return ({4'b0, v} << 3) + {4'b0, v};
  endfunction

  // configuration
  logic [BW-1:0]                min_growth, max_growth;
  logic [mgac_pkg::DIV_W-1:0]   head_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_growth <= '0;
      max_growth <= '0;
      head_div   <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgac_pkg::REG_MIN_GROWTH: min_growth <= cfg_data;
        mgac_pkg::REG_MAX_GROWTH: max_growth <= cfg_data;
        mgac_pkg::REG_DIVISOR:    head_div   <= cfg_data[mgac_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // request fields
  logic [2:0]                   in_cmd;
  logic [mgac_pkg::DOM_W-1:0]   in_dom;
  logic [4:0]                   in_own, in_tk;
  logic [BW-1:0]                in_bytes, in_usage, in_budget;
  logic                         in_est;
  logic                         s_fire;

  assign s_fire = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_cmd    <= s_tdata[2:0];
      in_dom    <= s_tdata[5:3];
      in_own    <= s_tdata[10:6];
      in_bytes  <= s_tdata[58:11];
      in_tk     <= s_tdata[63:59];
      in_usage  <= s_tdata[111:64];
      in_budget <= s_tdata[159:112];
      in_est    <= s_tdata[160];
    end
  end

  // read addresses taken straight from the request
  logic [mgac_pkg::DOM_W-1:0]                 rd_dom;
  logic [mgac_pkg::DOM_W+mgac_pkg::OWN_W-1:0] rd_own_idx;
  logic [mgac_pkg::SLOT_W-1:0]                rd_slot;
  logic [3:0]                                 s_own_m1, s_tk_m1;

  assign rd_dom     = s_tdata[5:3];
  assign s_own_m1   = s_tdata[9:6] - 4'd1;
  assign s_tk_m1    = s_tdata[62:59] - 4'd1;
  assign rd_own_idx = {rd_dom, s_own_m1};
  assign rd_slot    = s_tk_m1;

  // memories
  mgac_pkg::dom_rec_t  dom_mem [mgac_pkg::DOMAINS];
  mgac_pkg::own_rec_t  own_mem [mgac_pkg::DOMAINS*mgac_pkg::OWNERS];
  mgac_pkg::slot_rec_t slot_mem[mgac_pkg::TICKETS];
  logic [mgac_pkg::DOMAINS-1:0]                 dom_vld;
  logic [mgac_pkg::DOMAINS*mgac_pkg::OWNERS-1:0] own_vld;
  logic [mgac_pkg::TICKETS-1:0]                 slot_busy;

  mgac_pkg::dom_rec_t  dom_q;
  mgac_pkg::own_rec_t  own_q;
  mgac_pkg::slot_rec_t slot_q;
  logic                dom_vq, own_vq;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      dom_q  <= dom_mem[rd_dom];
      own_q  <= own_mem[rd_own_idx];
      slot_q <= slot_mem[rd_slot];
      dom_vq <= dom_vld[rd_dom];
      own_vq <= own_vld[rd_own_idx];
    end
  end

  mgac_pkg::dom_rec_t cur;
  logic [BW-1:0]      own_cur;
  assign cur     = dom_vq ? dom_q : '0;
  assign own_cur = (own_vq && own_q.tag == cur.generation) ? own_q.bytes : '0;

  // divider for the headroom division of a budget update
  logic                       div_start, div_done;
  logic [BW-1:0]              div_dvd, div_q;
  logic [mgac_pkg::DIV_W-1:0] div_dsr;
  logic [BW-1:0]              head, q_head;

  assign head = (in_budget > in_usage) ? in_budget - in_usage : '0;

  mgac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_start = (state == S_READ) && (in_cmd == mgac_pkg::CMD_UPDATE);
  assign div_dvd   = head;
  assign div_dsr   = (head_div == '0) ? 16'd1 : head_div;

  // processing of one request
  mgac_pkg::dom_rec_t  nxt;
  logic [BW-1:0]       own_nxt;
  logic                own_we, slot_we, acc;
  logic [4:0]          granted;
  logic [mgac_pkg::SLOT_W-1:0] free_idx, tk_idx;
  logic                free_found, own_ok;
  logic [BW-1:0]       g, eff, used, after, rr;
  logic [BW+3:0]       eff_x5, aft_x10;
  logic                ok, match;

  assign tk_idx = in_tk[3:0] - 4'd1;
  assign own_ok = (in_own >= 5'd1) && (in_own <= 5'(mgac_pkg::OWNERS));

  // lowest free ticket slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = mgac_pkg::TICKETS - 1; i >= 0; i--) begin
      if (!slot_busy[i]) begin
        free_idx   = mgac_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    nxt     = cur;
    own_nxt = own_cur;
    own_we  = 1'b0;
    slot_we = 1'b0;
    acc     = 1'b0;
    granted = '0;
    g       = q_head;
    eff     = '0;
    eff_x5  = '0;
    aft_x10 = '0;
    used    = mgac_pkg::sat_add(cur.reserved, cur.committed);
    after   = '0;
    rr      = '0;
    ok      = 1'b0;
    match   = slot_busy[tk_idx] && own_ok && slot_q.owner == in_own[3:0] - 4'd1 &&
              slot_q.domain == in_dom && slot_q.bytes == in_bytes &&
              in_tk >= 5'd1 && in_tk <= 5'(mgac_pkg::TICKETS);
    case (in_cmd)
      mgac_pkg::CMD_UPDATE: begin
        // allowance from headroom, floor and cap
        if (head >= min_growth && g < min_growth) g = min_growth;
        if (max_growth != '0 && g > max_growth) g = max_growth;
        if (g > head) g = head;
        if (in_budget == '0) g = mgac_pkg::BMAX;
        else if (head == '0) g = '0;
        nxt.usage       = in_usage;
        nxt.budget      = in_budget;
        nxt.estimated   = in_est;
        nxt.generation  = cur.generation + 32'd1;
        nxt.allowance   = g;
        nxt.committed   = '0;
        // pressure hysteresis: stay above 80%, enter at 90% of budget
        eff    = mgac_pkg::sat_add(in_usage, cur.reserved);
        eff_x5 = mul5(eff);
        if (in_budget == '0 || in_est) nxt.pressure = 1'b0;
        else if (cur.pressure) nxt.pressure = eff_x5 >= (({4'b0, in_budget} << 2) + 52'd5);
        else nxt.pressure = (eff_x5 << 1) >= mul9(in_budget);
      end
      mgac_pkg::CMD_RESERVE: begin
        if (own_ok && in_bytes != '0) begin
          ok = !cur.pressure;
          if (ok && cur.budget != '0) begin
            ok = in_bytes <= cur.allowance && used <= cur.allowance - in_bytes;
            if (ok && !cur.estimated) begin
              // stay below the 90% enter level
              after   = mgac_pkg::sat_add(cur.usage, mgac_pkg::sat_add(used, in_bytes));
              aft_x10 = mul5(after) << 1;
              ok      = aft_x10 < mul9(cur.budget);
            end
          end
          if (ok && free_found) begin
            slot_we      = 1'b1;
            nxt.reserved = mgac_pkg::sat_add(cur.reserved, in_bytes);
            acc          = 1'b1;
            granted      = {1'b0, free_idx} + 5'd1;
          end
        end
      end
      mgac_pkg::CMD_COMMIT, mgac_pkg::CMD_CANCEL: begin
        if (match) begin
          nxt.reserved = mgac_pkg::clamp_sub(cur.reserved, in_bytes);
          if (in_cmd == mgac_pkg::CMD_COMMIT) begin
            nxt.committed = mgac_pkg::sat_add(cur.committed, in_bytes);
            own_nxt       = mgac_pkg::sat_add(own_cur, in_bytes);
            own_we        = 1'b1;
          end
          acc = 1'b1;
        end
      end
      mgac_pkg::CMD_ALLOC: begin
        if (own_ok && in_bytes != '0) begin
          nxt.committed = mgac_pkg::sat_add(cur.committed, in_bytes);
          own_nxt       = mgac_pkg::sat_add(own_cur, in_bytes);
          own_we        = 1'b1;
        end
      end
      mgac_pkg::CMD_RELEASE: begin
        if (own_ok && in_bytes != '0) begin
          rr            = (own_cur < in_bytes) ? own_cur : in_bytes;
          own_nxt       = own_cur - rr;
          nxt.committed = mgac_pkg::clamp_sub(cur.committed, rr);
          own_we        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  logic wb_fire;
  assign wb_fire = (state == S_WB) && (!m_tvalid || m_tready);

  // write-back into the memories
  always_ff @(posedge clk) begin
    if (wb_fire) begin
      dom_mem[in_dom] <= nxt;
      if (own_we) own_mem[{in_dom, in_own[3:0] - 4'd1}] <= '{tag: cur.generation, bytes: own_nxt};
      if (slot_we) slot_mem[free_idx] <= '{owner: in_own[3:0] - 4'd1, domain: in_dom,
                                           bytes: in_bytes};
    end
  end

  // valid and busy bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dom_vld   <= '0;
      own_vld   <= '0;
      slot_busy <= '0;
    end else if (wb_fire) begin
      dom_vld[in_dom] <= 1'b1;
      if (own_we) own_vld[{in_dom, in_own[3:0] - 4'd1}] <= 1'b1;
      if (slot_we) slot_busy[free_idx] <= 1'b1;
      else if (acc) slot_busy[tk_idx] <= 1'b0;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !wb_fire) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: if (s_fire) state <= S_READ;
        S_READ: state <= (in_cmd == mgac_pkg::CMD_UPDATE) ? S_DIV : S_WB;
        S_DIV: if (div_done) begin
          q_head <= div_q;
          state  <= S_WB;
        end
        S_WB: if (wb_fire) begin
          m_tvalid <= 1'b1;
          m_tdata  <= {1'b0, nxt.generation,
                       mgac_pkg::sat_add(nxt.usage,
                                         mgac_pkg::sat_add(nxt.reserved, nxt.committed)),
                       nxt.committed, nxt.reserved, nxt.allowance, nxt.pressure,
                       granted, acc};
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mgac_checker.sv =====
module mgac_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [mgac_pkg::OUT_W-1:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // reset empties the output
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a granted ticket always comes with accepted
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:1] != 5'd0 |-> m_tdata[0])
    else $error("ticket without accept");

  // one request in work at a time
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while busy");

endmodule

bind memory_growth_admission_control_core mgac_checker u_mgac_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mgac_pkg::*;

  localparam logic [2:0] CMD_QUERY = 3'd6;
  localparam logic [2:0] CMD_ODD   = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic          estimated;
    logic [BW-1:0] budget;
    logic [BW-1:0] usage;
    logic [4:0]    ticket;
    logic [BW-1:0] bytes;
    logic [4:0]    owner;
    logic [2:0]    domain;
    logic [2:0]    command;
  } request_t;

  typedef struct packed {
    logic [31:0]   generation;
    logic [BW-1:0] effective;
    logic [BW-1:0] committed;
    logic [BW-1:0] reserved;
    logic [BW-1:0] allowance;
    logic          pressure;
    logic [4:0]    granted;
    logic          accepted;
  } snapshot_t;

  // directed row: request plus optional typed-in expectation
  typedef struct {
    request_t  req;
    bit        fixed;
    snapshot_t snap;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [BW-1:0] cfg_data = '0;

  memory_growth_admission_control_core DUT (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [BW-1:0] min_growth, max_growth;
  logic [15:0]   divisor;
  logic [BW-1:0] d_usage [DOMAINS], d_budget [DOMAINS], d_allow [DOMAINS];
  logic [BW-1:0] d_resv [DOMAINS], d_comm [DOMAINS];
  logic          d_est [DOMAINS], d_press [DOMAINS];
  logic [31:0]   d_gen [DOMAINS];
  logic [BW-1:0] own_comm [DOMAINS][OWNERS];
  logic          t_busy [TICKETS];
  logic [4:0]    t_owner [TICKETS];
  logic [2:0]    t_dom [TICKETS];
  logic [BW-1:0] t_bytes [TICKETS];

  snapshot_t pending_snapshots [$];
  int errors = 0, accepted_cnt = 0, result_cnt = 0, grant_cnt = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  bit sending = 1'b0;

  function automatic logic [BW-1:0] add_sat(logic [BW-1:0] a, logic [BW-1:0] b);
    logic [BW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BW] ? '1 : s[BW-1:0];
  endfunction

  function automatic logic [BW-1:0] sub_clamp(logic [BW-1:0] a, logic [BW-1:0] b);
    return (b < a) ? a - b : '0;
  endfunction

  function automatic logic [BW-1:0] growth_of(logic [BW-1:0] u, logic [BW-1:0] b);
    logic [BW-1:0] head, g;
    if (b == 0) return '1;
    head = (b > u) ? b - u : '0;
    if (head == 0) return '0;
    g = head / ((divisor == 0) ? 48'd1 : BW'(divisor));
    if (head >= min_growth && g < min_growth) g = min_growth;
    if (max_growth != 0 && g > max_growth) g = max_growth;
    return (g < head) ? g : head;
  endfunction

  task automatic predictor_reset();
    min_growth = '0; max_growth = '0; divisor = 16'd1;
    for (int d = 0; d < DOMAINS; d++) begin
      d_usage[d] = '0; d_budget[d] = '0; d_allow[d] = '0; d_resv[d] = '0;
      d_comm[d] = '0; d_est[d] = 0; d_press[d] = 0; d_gen[d] = '0;
      for (int o = 0; o < OWNERS; o++) own_comm[d][o] = '0;
    end
    for (int t = 0; t < TICKETS; t++) t_busy[t] = 0;
  endtask

  // admission decision for one request
  function automatic snapshot_t admit(request_t r);
    snapshot_t s;
    int d, oi, slot;
    bit own_ok, ok, was;
    logic [BW-1:0] used, ent, rel, eff, after, amt;
    s = '0;
    d = r.domain;
    own_ok = r.owner >= 1 && r.owner <= OWNERS;
    oi = own_ok ? r.owner - 1 : 0;
    case (r.command)
      CMD_UPDATE: begin
        was = d_press[d];
        d_usage[d] = r.usage; d_budget[d] = r.budget; d_est[d] = r.estimated;
        d_gen[d]++;
        d_allow[d] = growth_of(r.usage, r.budget);
        d_comm[d] = '0;
        for (int o = 0; o < OWNERS; o++) own_comm[d][o] = '0;
        if (r.budget == 0 || r.estimated) d_press[d] = 0;
        else begin
          eff = add_sat(r.usage, d_resv[d]);
          rel = r.budget - r.budget / 5;
          ent = r.budget - r.budget / 10;
          d_press[d] = was ? (eff > rel) : (eff >= ent);
        end
      end
      CMD_RESERVE: if (own_ok && r.bytes != 0) begin
        used = add_sat(d_resv[d], d_comm[d]);
        ok = !d_press[d];
        if (ok && d_budget[d] != 0) begin
          ok = r.bytes <= d_allow[d] && used <= d_allow[d] - r.bytes;
          if (ok && !d_est[d]) begin
            ent = d_budget[d] - d_budget[d] / 10;
            after = add_sat(d_usage[d], add_sat(used, r.bytes));
            ok = after < ent;
          end
        end
        if (ok) begin
          slot = -1;
          for (int t = TICKETS - 1; t >= 0; t--) if (!t_busy[t]) slot = t;
          if (slot >= 0) begin
            t_busy[slot] = 1; t_owner[slot] = r.owner; t_dom[slot] = r.domain;
            t_bytes[slot] = r.bytes;
            d_resv[d] = add_sat(d_resv[d], r.bytes);
            s.accepted = 1; s.granted = 5'(slot + 1);
          end
        end
      end
      CMD_COMMIT, CMD_CANCEL: if (r.ticket >= 1 && r.ticket <= TICKETS) begin
        slot = r.ticket - 1;
        if (t_busy[slot] && t_owner[slot] == r.owner && t_dom[slot] == r.domain &&
            t_bytes[slot] == r.bytes) begin
          d_resv[d] = sub_clamp(d_resv[d], r.bytes);
          if (r.command == CMD_COMMIT) begin
            d_comm[d] = add_sat(d_comm[d], r.bytes);
            if (own_ok) own_comm[d][oi] = add_sat(own_comm[d][oi], r.bytes);
          end
          t_busy[slot] = 0;
          s.accepted = 1;
        end
      end
      CMD_ALLOC: if (own_ok && r.bytes != 0) begin
        d_comm[d] = add_sat(d_comm[d], r.bytes);
        own_comm[d][oi] = add_sat(own_comm[d][oi], r.bytes);
      end
      CMD_RELEASE: if (own_ok && r.bytes != 0) begin
        amt = (own_comm[d][oi] < r.bytes) ? own_comm[d][oi] : r.bytes;
        own_comm[d][oi] -= amt;
        d_comm[d] = sub_clamp(d_comm[d], amt);
      end
      default: ;
    endcase
    s.pressure = d_press[d];
    s.allowance = d_allow[d];
    s.reserved = d_resv[d];
    s.committed = d_comm[d];
    s.effective = add_sat(d_usage[d], add_sat(d_resv[d], d_comm[d]));
    s.generation = d_gen[d];
    return s;
  endfunction

  // configuration write, block idle
  task automatic write_reg(logic [1:0] idx, logic [BW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_GROWTH: min_growth = val;
      REG_MAX_GROWTH: max_growth = val;
      default:        divisor = val[15:0];
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_snapshots.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // offer one request and record its expectation at acceptance
  task automatic send_request(request_t r, bit fixed, snapshot_t want, bit gaps);
    snapshot_t p;
    int gap;
    gap = gaps ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(r);
    do @(posedge clk); while (!(s_tready === 1'b1));
    p = admit(r);
    if (fixed && p != want) begin
      $display("%0t: table row disagrees with predictor: exp %h got %h", $realtime, want, p);
      errors++;
    end
    pending_snapshots.push_back(fixed ? want : p);
    accepted_cnt++;
  endtask

  function automatic logic [BW-1:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return BW'($urandom_range(1, 64));
      3: return BW'({$urandom, $urandom});
      default: return BW'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int slot;
    r = '0;
    r.command = 3'($urandom_range(0, 7));
    r.domain = 3'($urandom_range(0, 7));
    r.owner = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16));
    r.bytes = rand_bytes();
    r.ticket = 5'($urandom);
    r.usage = ($urandom_range(0, 3) == 0) ? BW'({$urandom, $urandom})
                                          : BW'($urandom_range(0, 60000));
    r.budget = ($urandom_range(0, 5) == 0) ? BW'({$urandom, $urandom})
                                           : BW'($urandom_range(0, 100000));
    r.estimated = $urandom_range(0, 4) == 0;
    // mostly well-formed commit/cancel of a live ticket
    if ((r.command == CMD_COMMIT || r.command == CMD_CANCEL) && $urandom_range(0, 3) != 0) begin
      slot = $urandom_range(0, TICKETS - 1);
      if (t_busy[slot]) begin
        r.ticket = 5'(slot + 1); r.owner = t_owner[slot];
        r.domain = t_dom[slot]; r.bytes = t_bytes[slot];
      end
    end
    if (r.command == CMD_RESERVE && $urandom_range(0, 2) != 0)
      r.bytes = BW'($urandom_range(1, 2000));
    return r;
  endfunction

  // result checking with random stalls and one long hold-off
  initial begin : result_side
    snapshot_t got, want;
    int idle_left;
    idle_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
        got = snapshot_t'(m_tdata[$bits(snapshot_t)-1:0]);
        result_cnt++;
        idle_left = $urandom_range(0, 6);
        if (got.accepted) grant_cnt++;
        if (pending_snapshots.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          errors++;
        end else begin
          want = pending_snapshots.pop_front();
          if (got.accepted !== want.accepted) begin
            $display("%0t: accepted exp %h got %h", $realtime, want.accepted, got.accepted); errors++; end
          if (got.granted !== want.granted) begin
            $display("%0t: granted_ticket exp %h got %h", $realtime, want.granted, got.granted); errors++; end
          if (got.pressure !== want.pressure) begin
            $display("%0t: memory_pressure exp %h got %h", $realtime, want.pressure, got.pressure); errors++; end
          if (got.allowance !== want.allowance) begin
            $display("%0t: growth_allowance exp %h got %h", $realtime, want.allowance, got.allowance); errors++; end
          if (got.reserved !== want.reserved) begin
            $display("%0t: reserved_total exp %h got %h", $realtime, want.reserved, got.reserved); errors++; end
          if (got.committed !== want.committed) begin
            $display("%0t: committed_total exp %h got %h", $realtime, want.committed, got.committed); errors++; end
          if (got.effective !== want.effective) begin
            $display("%0t: effective_usage exp %h got %h", $realtime, want.effective, got.effective); errors++; end
          if (got.generation !== want.generation) begin
            $display("%0t: snapshot_count exp %h got %h", $realtime, want.generation, got.generation); errors++; end
        end
      end
      if (hold_off) m_tready <= 1'b0;
      else if (idle_left != 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else m_tready <= 1'b1;
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    row_t rows [$];
    row_t row;
    request_t r;
    snapshot_t zero_snap;
    logic [BW-1:0] mins [3], maxs [3];
    logic [15:0] divs [3];
    predictor_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    zero_snap = '0;

    // directed table
    r = '0; r.command = CMD_QUERY; r.domain = 3'd7;
    row.req = r; row.fixed = 1; row.snap = zero_snap; rows.push_back(row);
    r.command = CMD_ODD; r.domain = 3'd0; row.req = r; rows.push_back(row);
    // invalid budget: allowance all ones
    r = '0; r.command = CMD_UPDATE; r.domain = 3'd1; r.usage = '1;
    row.req = r; row.snap = '0; row.snap.allowance = '1;
    row.snap.effective = '1; row.snap.generation = 1; rows.push_back(row);
    row.fixed = 0;
    r = '0; r.command = CMD_RESERVE; r.domain = 3'd1; r.owner = 5'd16; r.bytes = '1;
    row.req = r; rows.push_back(row);
    r.owner = 5'd0; r.bytes = 48'd5; row.req = r; rows.push_back(row);
    r.owner = 5'd31; row.req = r; rows.push_back(row);
    r.owner = 5'd1; r.bytes = '0; row.req = r; rows.push_back(row);
    // zero headroom, then normal budget
    r = '0; r.command = CMD_UPDATE; r.domain = 3'd2; r.usage = 48'd100; r.budget = 48'd100;
    row.req = r; rows.push_back(row);
    r.usage = 48'd10; r.budget = 48'd1000; row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_RESERVE; r.domain = 3'd2; r.owner = 5'd3; r.bytes = 48'd50;
    row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_COMMIT; r.domain = 3'd2; r.owner = 5'd3; r.bytes = 48'd50;
    r.ticket = 5'd1; row.req = r; rows.push_back(row);
    r.ticket = 5'd0; row.req = r; rows.push_back(row);
    r.ticket = 5'd31; row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_RESERVE; r.domain = 3'd2; r.owner = 5'd4; r.bytes = 48'd20;
    row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_CANCEL; r.domain = 3'd2; r.owner = 5'd5; r.bytes = 48'd20;
    r.ticket = 5'd1; row.req = r; rows.push_back(row);
    r.owner = 5'd4; row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_ALLOC; r.domain = 3'd2; r.owner = 5'd16; r.bytes = '1;
    row.req = r; rows.push_back(row);
    r.command = CMD_RELEASE; r.bytes = 48'd7; row.req = r; rows.push_back(row);
    r.owner = 5'd0; row.req = r; rows.push_back(row);
    // pressure enter, then release hysteresis
    r = '0; r.command = CMD_UPDATE; r.domain = 3'd3; r.usage = 48'd900; r.budget = 48'd1000;
    row.req = r; rows.push_back(row);
    r.usage = 48'd850; row.req = r; rows.push_back(row);
    r.usage = 48'd800; row.req = r; rows.push_back(row);
    r.usage = '1; r.budget = '1; r.estimated = 1; row.req = r; rows.push_back(row);
    r = '0; r.command = CMD_RESERVE; r.domain = 3'd3; r.owner = 5'd2; r.bytes = 48'd9;
    row.req = r; rows.push_back(row);
    foreach (rows[i]) send_request(rows[i].req, rows[i].fixed, rows[i].snap, 1);
    drain();

    // random phases over several configurations, extremes included
    mins = '{48'd0, 48'd500, '1};
    maxs = '{48'd0, 48'd300, '1};
    divs = '{16'd0, 16'd3, 16'hFFFF};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_MIN_GROWTH, (ph < 3) ? mins[ph] : BW'({$urandom, $urandom} % 64'd2000));
      write_reg(REG_MAX_GROWTH, (ph < 3) ? maxs[2 - ph] : BW'($urandom_range(0, 5000)));
      write_reg(REG_DIVISOR, (ph < 3) ? BW'(divs[ph]) : BW'($urandom_range(1, 8)));
      for (int n = 0; n < 85; n++) begin
        // receiver hold-off while requests keep coming
        if (ph == 1 && n == 10) fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        join_none
        // sender pause until all results are in
        if (ph == 2 && n == 40) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (pending_snapshots.size() != 0);
        end
        send_request(rand_request(), 0, zero_snap, !(ph == 3 && n < 30));
      end
      drain();
    end

    $display("Covered %0d requests (%0d results, %0d accepted) over 5 configurations,",
             accepted_cnt, result_cnt, grant_cnt);
    $display("including hold-off backpressure and idle sender pauses.");
    if (errors == 0 && pending_snapshots.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mgac_pkg.sv
hw/rtl/mgac_div.sv
hw/rtl/memory_growth_admission_control_core.sv
hw/rtl/mgac_checker.sv
tb/sv/tb_top.sv
